[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define MVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define MVT_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mvt_pkg.sv]
// Package for the matrix-vector transform unit: sizes, codes and payload types.
// No dependencies; used by every module of the block.
package mvt_pkg;

    // Active matrix size (1..4); the payload always carries MAX_DIM slots.
    localparam int DIM     = 4;
    localparam int MAX_DIM = 4;
    localparam int IDX_W   = 2;
    localparam int ENTRIES = MAX_DIM * MAX_DIM;

    // Q16.16 arithmetic widths
    localparam int Q_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * Q_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHIFT_W    = SUM_W - FRAC_W;
    localparam int ROUND_HALF = 2 ** (FRAC_W - 1);

    // Request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    // Vector queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef q_t [MAX_DIM-1:0]      vec_t;
    typedef q_t [ENTRIES-1:0]      mat_t;

    typedef struct packed {
        logic                  req_type;
        idx_t                  elem_row;
        idx_t                  elem_col;
        logic signed [Q_W-1:0] elem_value;
        logic signed [Q_W-1:0] vec_0;
        logic signed [Q_W-1:0] vec_1;
        logic signed [Q_W-1:0] vec_2;
        logic signed [Q_W-1:0] vec_3;
    } req_t;

    typedef struct packed {
        logic signed [Q_W-1:0] out_0;
        logic signed [Q_W-1:0] out_1;
        logic signed [Q_W-1:0] out_2;
        logic signed [Q_W-1:0] out_3;
    } res_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

[rtl/mvt_front.sv]
// Front end: takes requests, writes matrix loads, forwards transform vectors.
// Depends on mvt_pkg.
module mvt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mvt_pkg::req_t        req_data,
    input  mvt_pkg::qstat_t      qstat,
    output logic                 push,
    output mvt_pkg::vec_t        push_vec,
    output mvt_pkg::mat_t        matrix
);

    mvt_pkg::mat_t matrix_reg;
    mvt_pkg::mat_t matrix_next;
    logic          is_load;
    logic          in_range;
    logic          accept;
    logic          wr_en;
    logic [$clog2(mvt_pkg::ENTRIES)-1:0] wr_idx;

    // A load waits for queued vectors, which still have to read the old matrix.
    always_comb
    begin
        is_load   = (req_data.req_type == mvt_pkg::REQ_LOAD);
        req_stall = qstat.full | (is_load & ~qstat.empty);
        accept    = req_valid & ~req_stall;
        push      = accept & ~is_load;
        in_range  = (32'(req_data.elem_row) < mvt_pkg::DIM) &&
                    (32'(req_data.elem_col) < mvt_pkg::DIM);
        wr_en     = accept & is_load & in_range;
        wr_idx    = {req_data.elem_row, req_data.elem_col};
    end

    always_comb
    begin
        push_vec[0] = req_data.vec_0;
        push_vec[1] = req_data.vec_1;
        push_vec[2] = req_data.vec_2;
        push_vec[3] = req_data.vec_3;
    end

    always_comb
    begin
        matrix_next = matrix_reg;
        if (wr_en)
        begin
            matrix_next[wr_idx] = req_data.elem_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= '0;
        end
        else
        begin
            matrix_reg <= matrix_next;
        end
    end

    assign matrix = matrix_reg;

endmodule

[rtl/mvt_queue.sv]
// Short FIFO of transform vectors between the front end and the datapath.
// Depends on mvt_pkg.
module mvt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mvt_pkg::vec_t        push_vec,
    input  logic                 pop,
    output mvt_pkg::vec_t        head_vec,
    output mvt_pkg::qstat_t      qstat
);

    mvt_pkg::vec_t                 entry_reg [mvt_pkg::Q_DEPTH];
    logic [mvt_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mvt_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mvt_pkg::QCNT_W-1:0]    count_reg, count_next;

    function automatic logic [mvt_pkg::QPTR_W-1:0] ptr_inc(
        input logic [mvt_pkg::QPTR_W-1:0] p
    );
        if (p == mvt_pkg::QPTR_W'(mvt_pkg::Q_DEPTH - 1))
        begin
            return '0;
        end
        return p + mvt_pkg::QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + mvt_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - mvt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_vec;
        end
    end

    assign head_vec    = entry_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == mvt_pkg::QCNT_W'(mvt_pkg::Q_DEPTH));

endmodule

[rtl/mvt_back.sv]
// Datapath: multiply, pair sums, row sums with rounding, saturation and output register.
// Depends on mvt_pkg.
module mvt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mvt_pkg::qstat_t      qstat,
    input  mvt_pkg::vec_t        head_vec,
    input  mvt_pkg::mat_t        matrix,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output mvt_pkg::res_t        res_data
);

    localparam int M = mvt_pkg::MAX_DIM;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [mvt_pkg::PROD_W-1:0]  prod_reg  [mvt_pkg::ENTRIES];
    logic signed [mvt_pkg::PROD_W-1:0]  prod_next [mvt_pkg::ENTRIES];
    logic signed [mvt_pkg::PAIR_W-1:0]  pair_reg  [M][2];
    logic signed [mvt_pkg::PAIR_W-1:0]  pair_next [M][2];
    logic signed [mvt_pkg::SUM_W-1:0]   sum_reg   [M];
    logic signed [mvt_pkg::SUM_W-1:0]   sum_next  [M];
    mvt_pkg::vec_t                      sat;
    mvt_pkg::res_t                      res_reg, res_next;

    // Each stage moves when it is empty or when the one after it moves.
    always_comb
    begin
        en4 = ~v4_reg | ~res_stall;
        en3 = ~v3_reg | en4;
        en2 = ~v2_reg | en3;
        en1 = ~v1_reg | en2;
        pop = ~qstat.empty & en1;
    end

    // Stage 1: one 32x32 signed product per matrix entry
    always_comb
    begin
        for (int r = 0; r < M; r++)
        begin
            for (int c = 0; c < M; c++)
            begin
                if (r < mvt_pkg::DIM && c < mvt_pkg::DIM)
                begin
                    prod_next[r*M+c] = $signed(matrix[r*M+c]) * $signed(head_vec[c]);
                end
                else
                begin
                    prod_next[r*M+c] = '0;
                end
            end
        end
    end

    // Stage 2: pair sums; the rounding half LSB rides on the first pair
    always_comb
    begin
        for (int r = 0; r < M; r++)
        begin
            pair_next[r][0] = mvt_pkg::PAIR_W'(prod_reg[r*M+0])
                            + mvt_pkg::PAIR_W'(prod_reg[r*M+1])
                            + mvt_pkg::PAIR_W'(mvt_pkg::ROUND_HALF);
            pair_next[r][1] = mvt_pkg::PAIR_W'(prod_reg[r*M+2])
                            + mvt_pkg::PAIR_W'(prod_reg[r*M+3]);
        end
    end

    // Stage 3: full row sum
    always_comb
    begin
        for (int r = 0; r < M; r++)
        begin
            sum_next[r] = mvt_pkg::SUM_W'(pair_reg[r][0]) + mvt_pkg::SUM_W'(pair_reg[r][1]);
        end
    end

    // Stage 4: drop fraction bits (floor), clamp to 32 bits
    always_comb
    begin
        logic signed [mvt_pkg::SHIFT_W-1:0] sh;
        logic [mvt_pkg::SHIFT_W-mvt_pkg::Q_W:0] hi;
        for (int r = 0; r < M; r++)
        begin
            sh = sum_reg[r][mvt_pkg::SUM_W-1:mvt_pkg::FRAC_W];
            hi = sh[mvt_pkg::SHIFT_W-1:mvt_pkg::Q_W-1];
            if (r >= mvt_pkg::DIM)
            begin
                sat[r] = '0;
            end
            else if (&hi || ~|hi)
            begin
                sat[r] = sh[mvt_pkg::Q_W-1:0];
            end
            else if (sh[mvt_pkg::SHIFT_W-1])
            begin
                sat[r] = {1'b1, {(mvt_pkg::Q_W-1){1'b0}}};
            end
            else
            begin
                sat[r] = {1'b0, {(mvt_pkg::Q_W-1){1'b1}}};
            end
        end
        res_next.out_0 = sat[0];
        res_next.out_1 = sat[1];
        res_next.out_2 = sat[2];
        res_next.out_3 = sat[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pop;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg <= prod_next;
        end
        if (en2)
        begin
            pair_reg <= pair_next;
        end
        if (en3)
        begin
            sum_reg <= sum_next;
        end
        if (en4)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = v4_reg;
    assign res_data  = res_reg;

endmodule

[rtl/matrix_vector_transform_unit.sv]
// Matrix-vector transform unit: 4x4 Q16.16 matrix times a Q16.16 vector, one
// transform request per cycle sustained while the result side does not stall.
// A load request writes one matrix entry (rows or columns outside the active
// size are dropped) and gives no result; a transform request gives one result,
// four dot products rounded half up to Q16.16 and saturated to the signed
// 32-bit range. The matrix is all zero after reset. A transform passes from the
// vector queue through the product, pair-sum, row-sum and output registers;
// the rate is set by the sixteen parallel 32x32 multipliers of the first
// datapath stage, which take a new vector every cycle unless stalled. A load
// right after a transform waits until the vector queue has drained into the
// multipliers, so earlier vectors see the matrix as it was when accepted.
module matrix_vector_transform_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mvt_pkg::req_t        req_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output mvt_pkg::res_t        res_data
);

    mvt_pkg::qstat_t  qstat;
    mvt_pkg::vec_t    push_vec;
    mvt_pkg::vec_t    head_vec;
    mvt_pkg::mat_t    matrix;
    logic             push;
    logic             pop;

    // Front: request classification and matrix store
    mvt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .qstat     (qstat),
        .push      (push),
        .push_vec  (push_vec),
        .matrix    (matrix)
    );

    // Decoupling queue: transform vectors only
    mvt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_vec (push_vec),
        .pop      (pop),
        .head_vec (head_vec),
        .qstat    (qstat)
    );

    // Back: four-stage multiply/accumulate pipeline with output register
    mvt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head_vec  (head_vec),
        .matrix    (matrix),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

[rtl/mvt_checker.sv]
// Port-level checker for the matrix-vector transform unit, bound to the top level.
// Depends on mvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mvt_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  mvt_pkg::req_t        req_data,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  mvt_pkg::res_t        res_data
);

    // A stalled result keeps its value
    `MVT_ASSERT(ast_res_hold, res_valid && res_stall |=> res_valid && $stable(res_data), "result changed while stalled")

    // A result goes away only after it was taken
    `MVT_ASSERT(ast_res_drop, $fell(res_valid) |-> $past(!res_stall), "result dropped before taken")

    // A load never overtakes the vector accepted just before it
    `MVT_ASSERT(ast_load_order, req_valid && !req_stall && req_data.req_type == mvt_pkg::REQ_XFORM |=> !(req_valid && !req_stall && req_data.req_type == mvt_pkg::REQ_LOAD), "load accepted behind queued vector")

    // Nothing comes out while reset is held
    `MVT_ASSERT_ANY(ast_reset_quiet, !rst_n |-> !res_valid, "result valid during reset")

endmodule

bind matrix_vector_transform_unit mvt_checker u_mvt_checker (.*);

[dv/matrix_vector_transform_unit_test.sv]
// Self-checking testbench for matrix_vector_transform_unit: walks a directed
// table of requests, then a random stream, against a Q16.16 transform predictor.
// Depends on rtl/mvt_pkg.sv and rtl/matrix_vector_transform_unit.sv.
`timescale 1ns / 100ps

module matrix_vector_transform_unit_test;
    import mvt_pkg::*;

    // Receiver hold used to back the block up into its request side.
    localparam int LONG_HOLD = 60;
    // Enough idle cycles to cover the transform path after the last result.
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        req_t request;
        bit   typed;   // expected product written into the table
        res_t product;
    } plan_row_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req_data;
    logic  res_valid;
    logic  res_stall = 1'b0;
    res_t  res_data;

    // Predictor state: the matrix as the block should hold it after every
    // accepted request, and the products still owed by the block.
    q_t        matrix_now [ENTRIES];
    res_t      owed_products [$];
    plan_row_t directed_plan [$];

    int errors        = 0;
    int issued        = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    bit quiet         = 1'b0;

    matrix_vector_transform_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Each product component is summed exactly (66 bits cover four 64-bit
    // products), rounded half up by adding half an LSB and flooring, then
    // clamped to the signed 32-bit range. Components past DIM read zero.
    function automatic res_t transform_vector(input req_t r);
        q_t                 v [MAX_DIM];
        q_t                 o [MAX_DIM];
        logic signed [65:0] acc;
        res_t               p;
        v[0] = r.vec_0;
        v[1] = r.vec_1;
        v[2] = r.vec_2;
        v[3] = r.vec_3;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            o[i] = '0;
            if (i < DIM)
            begin
                acc = 66'sd32768;
                for (int c = 0; c < DIM; c++)
                    acc = acc + matrix_now[i * MAX_DIM + c] * v[c];
                acc = acc >>> FRAC_W;
                if (acc > 66'sd2147483647)
                    o[i] = 32'sh7FFF_FFFF;
                else if (acc < -66'sd2147483648)
                    o[i] = 32'sh8000_0000;
                else
                    o[i] = acc[31:0];
            end
        end
        p.out_0 = o[0];
        p.out_1 = o[1];
        p.out_2 = o[2];
        p.out_3 = o[3];
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Request builders; fields that the request type ignores get noise.
    // ------------------------------------------------------------------

    function automatic req_t load_req(input idx_t row, input idx_t col, input q_t val);
        req_t r;
        r.req_type   = REQ_LOAD;
        r.elem_row   = row;
        r.elem_col   = col;
        r.elem_value = val;
        r.vec_0      = $urandom;
        r.vec_1      = $urandom;
        r.vec_2      = $urandom;
        r.vec_3      = $urandom;
        return r;
    endfunction

    function automatic req_t xform_req(input q_t v0, input q_t v1, input q_t v2,
                                       input q_t v3);
        req_t r;
        r.req_type   = REQ_XFORM;
        r.elem_row   = idx_t'($urandom_range(0, MAX_DIM - 1));
        r.elem_col   = idx_t'($urandom_range(0, MAX_DIM - 1));
        r.elem_value = $urandom;
        r.vec_0      = v0;
        r.vec_1      = v1;
        r.vec_2      = v2;
        r.vec_3      = v3;
        return r;
    endfunction

    // Value mix: the rails, zero, +-1.0, +-0.5 (rounding ties), small
    // values that stay clear of saturation, and full-range noise.
    function automatic q_t rand_q();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return ($urandom_range(0, 1) != 0) ? 32'sh0001_0000 : 32'shFFFF_0000;
            4: return ($urandom_range(0, 1) != 0) ? 32'sh0000_8000 : 32'shFFFF_8000;
            5, 6: return q_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return q_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Called at a
    // rising edge; returns at the edge of acceptance, so the next call can
    // keep req_valid high without a bubble.
    task automatic issue(input req_t r, input bit typed, input res_t want);
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        issued++;
        if (r.req_type == REQ_LOAD)
        begin
            // rows or columns outside the active size are dropped
            if (r.elem_row < DIM && r.elem_col < DIM)
                matrix_now[r.elem_row * MAX_DIM + r.elem_col] = r.elem_value;
        end
        else
            owed_products.push_back(typed ? want : transform_vector(r));
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    task automatic send(input req_t r);
        maybe_gap();
        issue(r, 1'b0, '0);
    endtask

    task automatic plan(input req_t r, input bit typed, input res_t want);
        plan_row_t row;
        row.request = r;
        row.typed   = typed;
        row.product = want;
        directed_plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall bursts, plus a long hold on request from the
    // stimulus thread, counted here.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD - 1;
            res_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            hold_left <= $urandom_range(0, 8);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    task automatic check_field(input string name, input q_t want, input q_t got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (owed_products.size() == 0)
            begin
                $error("unexpected result %h", res_data);
                errors++;
            end
            else
            begin
                want = owed_products.pop_front();
                check_field("out_0", want.out_0, res_data.out_0);
                check_field("out_1", want.out_1, res_data.out_1);
                check_field("out_2", want.out_2, res_data.out_2);
                check_field("out_3", want.out_3, res_data.out_3);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int row;
        int col;
        int burst;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        foreach (matrix_now[i])
            matrix_now[i] = '0;

        // Directed table. Typed products are the ones read off directly:
        // a zero matrix after reset, single diagonal entries at the rails,
        // and a half-LSB tie in row 3 (1 LSB times 0.5).
        plan(xform_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF),
             1'b1, '0);
        plan(xform_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000),
             1'b1, '0);
        plan(load_req(2'd0, 2'd0, 32'sh0001_0000), 1'b0, '0);
        plan(load_req(2'd1, 2'd1, 32'sh7FFF_FFFF), 1'b0, '0);
        plan(load_req(2'd2, 2'd2, 32'sh8000_0000), 1'b0, '0);
        plan(load_req(2'd3, 2'd3, 32'sh0000_0001), 1'b0, '0);
        // identity row, saturate high, saturate low, tie rounds up
        plan(xform_req(32'sh1234_5678, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_8000),
             1'b1, res_t'({32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}));
        // most negative passes exactly, saturate low, min*min saturates
        // high, negative tie rounds up to zero
        plan(xform_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'shFFFF_8000),
             1'b1, res_t'({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000}));
        // load straight behind a transform; vector fields are noise
        plan(load_req(2'd0, 2'd1, 32'shFFFF_FFFF), 1'b0, '0);
        plan(xform_req(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0001),
             1'b0, '0);
        // row 0 at the rail: four large products, each past the 32-bit range alone
        for (int c = 0; c < MAX_DIM; c++)
            plan(load_req(2'd0, idx_t'(c), 32'sh7FFF_FFFF), 1'b0, '0);
        plan(xform_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF),
             1'b0, '0);
        plan(xform_req(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0001, 32'shFFFF_FFFF),
             1'b0, '0);
        plan(load_req(2'd3, 2'd0, 32'sh8000_0000), 1'b0, '0);
        plan(load_req(2'd1, 2'd1, 32'sh0000_0000), 1'b0, '0);
        plan(xform_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_0000, 32'sh0000_8000),
             1'b0, '0);

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            maybe_gap();
            issue(directed_plan[i].request, directed_plan[i].typed,
                  directed_plan[i].product);
        end

        // Sender pause: nothing offered until every product is back.
        req_valid <= 1'b0;
        while (owed_products.size() != 0)
            @(posedge clk);

        // Long receiver hold while transforms stream back to back; the
        // pipeline and vector queue fill and req_stall rises.
        hold_requests <= hold_requests + 1;
        repeat (24)
            issue(xform_req(rand_q(), rand_q(), rand_q(), rand_q()), 1'b0, '0);

        // Random stream: mostly transforms, with whole-matrix reloads that
        // are followed by a run of vectors, and scattered single loads.
        while (issued < 470)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    for (int e = 0; e < ENTRIES; e++)
                        send(load_req(idx_t'(e / MAX_DIM), idx_t'(e % MAX_DIM), rand_q()));
                    burst = $urandom_range(4, 10);
                    repeat (burst)
                        send(xform_req(rand_q(), rand_q(), rand_q(), rand_q()));
                end
                1, 2, 3:
                begin
                    row = $urandom_range(0, MAX_DIM - 1);
                    col = $urandom_range(0, MAX_DIM - 1);
                    send(load_req(idx_t'(row), idx_t'(col), rand_q()));
                end
                default:
                    send(xform_req(rand_q(), rand_q(), rand_q(), rand_q()));
            endcase
        end

        // Closing stretch at full rate on both sides, loads mixed in so a
        // load lands right behind a transform with no gap.
        quiet <= 1'b1;
        while (issued < 555)
        begin
            if ($urandom_range(0, 3) == 0)
                send(load_req(idx_t'($urandom_range(0, MAX_DIM - 1)),
                              idx_t'($urandom_range(0, MAX_DIM - 1)), rand_q()));
            else
                send(xform_req(rand_q(), rand_q(), rand_q(), rand_q()));
        end
        req_valid <= 1'b0;

        while (owed_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[matrix_vector_transform_unit.f]
+incdir+rtl
rtl/mvt_pkg.sv
rtl/mvt_front.sv
rtl/mvt_queue.sv
rtl/mvt_back.sv
rtl/matrix_vector_transform_unit.sv
rtl/mvt_checker.sv
dv/matrix_vector_transform_unit_test.sv
